>>> src/position_kalman_landmark_snap_macros.svh
// assertion macros for the landmark snap kalman block
`ifndef POSITION_KALMAN_LANDMARK_SNAP_MACROS_SVH
`define POSITION_KALMAN_LANDMARK_SNAP_MACROS_SVH

// implication checked on every clock, quiet in reset
`define PKLS_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked on every clock, quiet in reset
`define PKLS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/pkls_pkg.sv
// package: types, register indexes and constants for the landmark snap kalman block
package pkls_pkg;

    typedef struct packed {
        logic signed [31:0] meas_x;
        logic signed [31:0] meas_y;
    } pkls_in_t;

    typedef struct packed {
        logic signed [31:0] est_x;
        logic signed [31:0] est_y;
        logic [2:0]         landmark_hits;
    } pkls_out_t;

    typedef enum logic [2:0] {
        REG_PROC_VAR  = 3'd0,
        REG_MEAS_VAR  = 3'd1,
        REG_INIT_VAR  = 3'd2,
        REG_SNAP_RAD  = 3'd3,
        REG_LMARK_A   = 3'd4,
        REG_LMARK_B   = 3'd5,
        REG_LMARK_C   = 3'd6,
        REG_NONE      = 3'd7
    } pkls_reg_t;

    localparam logic [31:0] PROC_VAR_RST = 32'd19661;
    localparam logic [31:0] MEAS_VAR_RST = 32'd32768;
    localparam logic [31:0] INIT_VAR_RST = 32'd6554;
    localparam logic [31:0] SNAP_RAD_RST = 32'd147456;
    localparam logic [63:0] LMARK_A_RST  = 64'd703687441776640;
    localparam logic [63:0] LMARK_B_RST  = 64'd1407374883717120;
    localparam logic [63:0] LMARK_C_RST  = 64'd703687442104320;

    localparam int GAIN_BITS = 31;   // q1.30 gain, 0..2^30
    localparam int NUM_LMARK = 3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PRED,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_MUL_X,
        ST_MUL_Y,
        ST_MUL_P,
        ST_APPLY,
        ST_DIST_X,
        ST_DIST_Y,
        ST_DIST_CMP,
        ST_OUT
    } pkls_state_t;

    // divider request and answer
    typedef struct packed {
        logic        start;
        logic [62:0] num;
        logic [32:0] den;
    } pkls_div_req_t;

    typedef struct packed {
        logic        done;
        logic [30:0] quo;
    } pkls_div_rsp_t;

endpackage

>>> src/pkls_div.sv
// restoring divider: one quotient bit per cycle, 31-bit quotient register, no clamp
module pkls_div
    import pkls_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  pkls_div_req_t req,
    output pkls_div_rsp_t rsp
);

    logic [62:0] num_reg, num_next;
    logic [32:0] den_reg, den_next;
    logic [33:0] rem_reg, rem_next;
    logic [30:0] quo_reg, quo_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [33:0] trial;

    // one shift-subtract step a cycle, msb of numerator first
    always_comb begin
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = '0;
        if (req.start) begin
            num_next  = req.num;
            den_next  = req.den;
            rem_next  = '0;
            quo_next  = '0;
            cnt_next  = 6'd63;
            busy_next = (req.den != '0);
            done_next = (req.den == '0);
        end else if (busy_reg) begin
            trial    = {rem_reg[32:0], num_reg[62]};
            num_next = {num_reg[61:0], 1'b0};
            if (trial >= {1'b0, den_reg}) begin
                rem_next = trial - {1'b0, den_reg};
                quo_next = {quo_reg[29:0], 1'b1};
            end else begin
                rem_next = trial;
                quo_next = {quo_reg[29:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    // quotient p*2^30/(p+r) never exceeds 2^30 so 31 bits hold it
    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

>>> src/position_kalman_landmark_snap.sv
// top level: scalar-variance kalman filter for 2d position with landmark snapping
//
//  channel  ports               dir  payload
//  input    s_valid/s_ready     in   pkls_in_t  (meas_x, meas_y)
//  result   m_valid/m_ready     out  pkls_out_t (est_x, est_y, landmark_hits)
//  config   cfg_we/idx/data     in   register index 0..6, 64-bit data
//
// an update covers the 63-step gain divider plus its start and wait states,
// three multiplies on one shared 33x33 multiplier and the apply step; an item
// runs accept, predict, one update, three landmark checks and output, plus one
// more update per landmark hit
// the seeding item only loads the position and gives no result
// s_ready is high whenever the sequencer is idle; a finished item waits in the
// output state until the output register is free
// reset is synchronous, active low, and restores the filter state and configuration
`include "position_kalman_landmark_snap_macros.svh"

module position_kalman_landmark_snap
    import pkls_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  pkls_in_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output pkls_out_t   m_data,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_idx,
    input  logic [63:0] cfg_data
);

    // configuration registers
    logic [31:0] proc_var_reg, meas_var_reg, init_var_reg, snap_rad_reg;
    logic [63:0] lmark_reg [NUM_LMARK];

    // filter state
    logic signed [31:0] pos_x_reg, pos_x_next, pos_y_reg, pos_y_next;
    logic [31:0]        var_reg, var_next;
    logic               seeded_reg, seeded_next;

    // sequencer
    pkls_state_t        state_reg, state_next;
    logic signed [31:0] zx_reg, zx_next, zy_reg, zy_next;
    logic [30:0]        gain_reg, gain_next;
    logic [1:0]         lm_reg, lm_next;
    logic               lm_mode_reg, lm_mode_next;
    logic [2:0]         hits_reg, hits_next;
    logic [63:0]        prod_reg, prod_next;
    logic               negx_reg, negx_next, negy_reg, negy_next;
    logic [32:0]        stepx_reg, stepx_next;
    logic [32:0]        acc_reg, acc_next;
    pkls_out_t          out_reg, out_next;
    logic               m_valid_reg, m_valid_next;

    pkls_div_req_t div_req;
    pkls_div_rsp_t div_rsp;

    // shared multiplier operands
    logic [32:0] mul_a, mul_b;
    logic [65:0] mul_p;

    logic signed [32:0] diff;
    logic [32:0]        mag;
    logic [32:0]        psum;
    logic signed [33:0] newpos;
    logic [33:0]        dist_sum;
    logic signed [31:0] lx, ly;
    logic [33:0]        step_r;

    pkls_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign lx = lmark_reg[lm_reg][63:32];
    assign ly = lmark_reg[lm_reg][31:0];
    assign mul_p = mul_a * mul_b;

    // sequencer: predict, divide, three multiplies, apply, then landmark checks; a hit reruns the update
    always_comb begin
        state_next   = state_reg;
        pos_x_next   = pos_x_reg;
        pos_y_next   = pos_y_reg;
        var_next     = var_reg;
        seeded_next  = seeded_reg;
        zx_next      = zx_reg;
        zy_next      = zy_reg;
        gain_next    = gain_reg;
        lm_next      = lm_reg;
        lm_mode_next = lm_mode_reg;
        hits_next    = hits_reg;
        prod_next    = prod_reg;
        negx_next    = negx_reg;
        negy_next    = negy_reg;
        stepx_next   = stepx_reg;
        acc_next     = acc_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg;
        div_req      = '0;
        mul_a        = '0;
        mul_b        = '0;
        diff         = '0;
        mag          = '0;
        psum         = '0;
        newpos       = '0;
        dist_sum     = '0;
        step_r       = '0;
        s_ready      = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (!seeded_reg) begin
                        pos_x_next  = s_data.meas_x;
                        pos_y_next  = s_data.meas_y;
                        seeded_next = 1'b1;
                    end else begin
                        zx_next      = s_data.meas_x;
                        zy_next      = s_data.meas_y;
                        hits_next    = '0;
                        lm_mode_next = 1'b0;
                        lm_next      = '0;
                        state_next   = ST_PRED;
                    end
                end
            end
            ST_PRED: begin
                psum       = {1'b0, var_reg} + {1'b0, proc_var_reg};
                var_next   = psum[32] ? 32'hFFFF_FFFF : psum[31:0];
                state_next = ST_DIV_START;
            end
            ST_DIV_START: begin
                div_req.start = 1'b1;
                div_req.num   = {var_reg, 31'd0} >> 1;
                div_req.den   = {1'b0, var_reg} + {1'b0, meas_var_reg};
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_rsp.done) begin
                    gain_next  = div_rsp.quo;
                    state_next = ST_MUL_X;
                end
            end
            ST_MUL_X: begin
                // |zx - x| * k, rounded at bit 30
                diff       = 33'(zx_reg) - 33'(pos_x_reg);
                mag        = diff[32] ? 33'(-diff) : 33'(diff);
                negx_next  = diff[32];
                mul_a      = mag;
                mul_b      = {2'b0, gain_reg};
                step_r     = 34'((mul_p + 66'(1) * (66'd1 << 29)) >> 30);
                stepx_next = step_r[32:0];
                state_next = ST_MUL_Y;
            end
            ST_MUL_Y: begin
                diff       = 33'(zy_reg) - 33'(pos_y_reg);
                mag        = diff[32] ? 33'(-diff) : 33'(diff);
                negy_next  = diff[32];
                mul_a      = mag;
                mul_b      = {2'b0, gain_reg};
                step_r     = 34'((mul_p + (66'd1 << 29)) >> 30);
                acc_next   = step_r[32:0];
                state_next = ST_MUL_P;
            end
            ST_MUL_P: begin
                mul_a      = {1'b0, var_reg};
                mul_b      = 33'(31'h4000_0000 - gain_reg);
                prod_next  = 64'((mul_p + (66'd1 << 29)) >> 30);
                state_next = ST_APPLY;
            end
            ST_APPLY: begin
                newpos = negx_reg ? 34'(pos_x_reg) - 34'(stepx_reg)
                                  : 34'(pos_x_reg) + 34'(stepx_reg);
                if (newpos > 34'sd2147483647) pos_x_next = 32'sh7FFF_FFFF;
                else if (newpos < -34'sd2147483648) pos_x_next = 32'sh8000_0000;
                else pos_x_next = newpos[31:0];
                newpos = negy_reg ? 34'(pos_y_reg) - 34'(acc_reg)
                                  : 34'(pos_y_reg) + 34'(acc_reg);
                if (newpos > 34'sd2147483647) pos_y_next = 32'sh7FFF_FFFF;
                else if (newpos < -34'sd2147483648) pos_y_next = 32'sh8000_0000;
                else pos_y_next = newpos[31:0];
                var_next = prod_reg[31:0];
                if (lm_mode_reg) begin
                    hits_next[lm_reg] = 1'b1;
                    if (lm_reg == 2'd2) state_next = ST_OUT;
                    else begin
                        lm_next    = lm_reg + 2'd1;
                        state_next = ST_DIST_X;
                    end
                end else begin
                    lm_mode_next = 1'b1;
                    lm_next      = '0;
                    state_next   = ST_DIST_X;
                end
            end
            ST_DIST_X: begin
                // x square, saturated to all ones when it leaves 33 bits
                diff       = 33'(lx) - 33'(pos_x_reg);
                mag        = diff[32] ? 33'(-diff) : 33'(diff);
                mul_a      = mag;
                mul_b      = mag;
                acc_next   = (mul_p[65:49] != '0) ? '1 : mul_p[48:16];
                state_next = ST_DIST_Y;
            end
            ST_DIST_Y: begin
                diff       = 33'(ly) - 33'(pos_y_reg);
                mag        = diff[32] ? 33'(-diff) : 33'(diff);
                mul_a      = mag;
                mul_b      = mag;
                prod_next  = 64'(mul_p >> 16);
                state_next = ST_DIST_CMP;
            end
            ST_DIST_CMP: begin
                // squares fit in 50 bits; the sum goes to all ones when the y square leaves 33 bits
                if (prod_reg[63:33] != '0) dist_sum = '1;
                else dist_sum = 34'(acc_reg) + 34'(prod_reg[32:0]);
                if (dist_sum < 34'(snap_rad_reg)) begin
                    zx_next    = lx;
                    zy_next    = ly;
                    state_next = ST_DIV_START;
                end else if (lm_reg == 2'd2) begin
                    state_next = ST_OUT;
                end else begin
                    lm_next    = lm_reg + 2'd1;
                    state_next = ST_DIST_X;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg) begin
                    out_next.est_x         = pos_x_reg;
                    out_next.est_y         = pos_y_reg;
                    out_next.landmark_hits = hits_reg;
                    m_valid_next           = 1'b1;
                    state_next             = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // initial variance write reloads the variance before seeding
        if (cfg_we && cfg_idx == REG_INIT_VAR && !seeded_reg) begin
            var_next = cfg_data[31:0];
        end
    end

    // sequencer and filter registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            var_reg     <= INIT_VAR_RST;
            seeded_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            lm_mode_reg <= 1'b0;
            lm_reg      <= '0;
            hits_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            pos_x_reg   <= pos_x_next;
            pos_y_reg   <= pos_y_next;
            var_reg     <= var_next;
            seeded_reg  <= seeded_next;
            m_valid_reg <= m_valid_next;
            lm_mode_reg <= lm_mode_next;
            lm_reg      <= lm_next;
            hits_reg    <= hits_next;
        end
        zx_reg    <= zx_next;
        zy_reg    <= zy_next;
        gain_reg  <= gain_next;
        prod_reg  <= prod_next;
        negx_reg  <= negx_next;
        negy_reg  <= negy_next;
        stepx_reg <= stepx_next;
        acc_reg   <= acc_next;
        out_reg   <= out_next;
    end

    // configuration write port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            proc_var_reg <= PROC_VAR_RST;
            meas_var_reg <= MEAS_VAR_RST;
            init_var_reg <= INIT_VAR_RST;
            snap_rad_reg <= SNAP_RAD_RST;
            lmark_reg[0] <= LMARK_A_RST;
            lmark_reg[1] <= LMARK_B_RST;
            lmark_reg[2] <= LMARK_C_RST;
        end else if (cfg_we) begin
            case (pkls_reg_t'(cfg_idx))
                REG_PROC_VAR: proc_var_reg <= cfg_data[31:0];
                REG_MEAS_VAR: meas_var_reg <= cfg_data[31:0];
                REG_INIT_VAR: init_var_reg <= cfg_data[31:0];
                REG_SNAP_RAD: snap_rad_reg <= cfg_data[31:0];
                REG_LMARK_A:  lmark_reg[0] <= cfg_data;
                REG_LMARK_B:  lmark_reg[1] <= cfg_data;
                REG_LMARK_C:  lmark_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // checks on the sequencer
    `PKLS_ASSERT_IMP(a_gain_range, aclk, aresetn, state_reg == ST_MUL_X,
        gain_reg <= 31'h4000_0000, "gain above one")
    `PKLS_ASSERT_IMP(a_busy_not_ready, aclk, aresetn, state_reg != ST_IDLE,
        !s_ready, "ready while busy")
    `PKLS_ASSERT_NEXT(a_result_seeded, aclk, aresetn, !m_valid_reg && m_valid_next,
        seeded_reg, "result before seeding")

endmodule

>>> tb/tb.sv
// self-checking testbench for the landmark snap kalman block
module tb;
    import pkls_pkg::*;

    // expected estimates and the filter copy that produces them
    class estimate_board;
        pkls_out_t pending_q[$];
        logic [31:0] proc_var, meas_var, init_var, snap_rad;
        logic [63:0] lmark[3];
        logic signed [31:0] px, py;
        logic [31:0] pvar;
        bit seeded;
        int errors;

        function void reset_state();
            proc_var = PROC_VAR_RST; meas_var = MEAS_VAR_RST;
            init_var = INIT_VAR_RST; snap_rad = SNAP_RAD_RST;
            lmark[0] = LMARK_A_RST; lmark[1] = LMARK_B_RST; lmark[2] = LMARK_C_RST;
            px = 0; py = 0; pvar = INIT_VAR_RST; seeded = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [63:0] d);
            case (idx)
                REG_PROC_VAR: proc_var = d[31:0];
                REG_MEAS_VAR: meas_var = d[31:0];
                REG_INIT_VAR: begin
                    init_var = d[31:0];
                    if (!seeded) pvar = d[31:0];
                end
                REG_SNAP_RAD: snap_rad = d[31:0];
                REG_LMARK_A: lmark[0] = d;
                REG_LMARK_B: lmark[1] = d;
                REG_LMARK_C: lmark[2] = d;
                default: ;
            endcase
        endfunction

        function logic signed [31:0] step_toward(logic signed [31:0] e,
                logic signed [31:0] z, logic [63:0] k);
            logic signed [33:0] diff;
            logic [63:0] mag, stp;
            logic signed [34:0] nv;
            diff = 34'(z) - 34'(e);
            mag = diff < 0 ? 64'(-diff) : 64'(diff);
            stp = (mag * k + 64'd536870912) >> 30;
            nv = diff < 0 ? 35'(e) - 35'(stp) : 35'(e) + 35'(stp);
            if (nv > 35'sd2147483647) return 32'h7fffffff;
            if (nv < -35'sd2147483648) return 32'h80000000;
            return nv[31:0];
        endfunction

        function void correct(logic signed [31:0] zx, logic signed [31:0] zy);
            logic [63:0] p, s, k;
            p = pvar; s = p + meas_var; k = 0;
            if (s != 0) k = (p << 30) / s;
            if (k > 64'd1073741824) k = 64'd1073741824;
            px = step_toward(px, zx, k);
            py = step_toward(py, zy, k);
            pvar = 32'((p * (64'd1073741824 - k) + 64'd536870912) >> 30);
        endfunction

        function logic [63:0] sq16(logic signed [31:0] a, logic signed [31:0] b);
            logic signed [33:0] d;
            logic [63:0] m;
            d = 34'(a) - 34'(b);
            m = d < 0 ? 64'(-d) : 64'(d);
            return (m * m) >> 16;
        endfunction

        function void note_input(pkls_in_t it);
            logic [32:0] sum;
            logic [63:0] d2;
            pkls_out_t r;
            logic signed [31:0] lx, ly;
            if (!seeded) begin
                px = it.meas_x; py = it.meas_y; seeded = 1;
                return;
            end
            sum = 33'(pvar) + 33'(proc_var);
            pvar = sum[32] ? 32'hffffffff : sum[31:0];
            correct(it.meas_x, it.meas_y);
            r.landmark_hits = 0;
            for (int i = 0; i < 3; i++) begin
                lx = lmark[i][63:32]; ly = lmark[i][31:0];
                d2 = sq16(lx, px) + sq16(ly, py);
                if (d2 > 64'hffffffff) d2 = 64'hffffffff;
                if (d2 < 64'(snap_rad)) begin
                    correct(lx, ly);
                    r.landmark_hits[i] = 1'b1;
                end
            end
            r.est_x = px; r.est_y = py;
            pending_q.push_back(r);
        endfunction

        function void check_result(pkls_out_t got);
            pkls_out_t w;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            w = pending_q.pop_front();
            if (got.est_x !== w.est_x) begin
                $display("%0t: est_x expected %h actual %h", $time, w.est_x, got.est_x);
                errors++;
            end
            if (got.est_y !== w.est_y) begin
                $display("%0t: est_y expected %h actual %h", $time, w.est_y, got.est_y);
                errors++;
            end
            if (got.landmark_hits !== w.landmark_hits) begin
                $display("%0t: landmark_hits expected %h actual %h", $time,
                         w.landmark_hits, got.landmark_hits);
                errors++;
            end
        endfunction
    endclass

    logic aclk, aresetn, s_valid, s_ready, m_valid, m_ready, cfg_we;
    pkls_in_t s_data;
    pkls_out_t m_data;
    logic [2:0] cfg_idx;
    logic [63:0] cfg_data;
    int send_idle, recv_idle;
    longint cycles;
    estimate_board board;

    position_kalman_landmark_snap i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
    );

    // clock
    initial begin
        aclk = 0;
        forever #4 aclk = ~aclk;
    end

    // watchdog
    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > 4000000) begin
                $display("position_kalman_landmark_snap test failed");
                $finish;
            end
        end
    end

    // result side: ready at random, check on accept
    initial begin
        m_ready = 0;
        forever begin
            @(negedge aclk);
            m_ready <= ($urandom_range(99) >= recv_idle);
        end
    end
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) board.check_result(m_data);
    end

    // valid stays high past the accept until the next idle, drain or write
    task automatic send_item(logic [31:0] x, logic [31:0] y);
        pkls_in_t it;
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 0;
            @(negedge aclk);
        end
        it.meas_x = x; it.meas_y = y;
        s_valid <= 1; s_data <= it;
        do @(posedge aclk); while (!s_ready);
        board.note_input(it);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 0;
        while (board.pending_q.size() != 0) @(negedge aclk);
        repeat (400) @(negedge aclk);
    endtask

    task automatic write_cfg(logic [2:0] idx, logic [63:0] d);
        s_valid <= 0;
        cfg_we <= 1; cfg_idx <= idx; cfg_data <= d;
        @(negedge aclk);
        board.write_reg(idx, d);
        cfg_we <= 0;
        @(negedge aclk);
    endtask

    function automatic logic [31:0] near_coord();
        return 32'($signed($urandom_range(458752)) - 65536);
    endfunction

    // random item: mostly near the landmarks, some anywhere
    task automatic send_random();
        if ($urandom_range(9) < 7) send_item(near_coord(), near_coord());
        else send_item($urandom, $urandom);
    endtask

    initial begin
        board = new();
        board.reset_state();
        board.errors = 0;
        aresetn = 0; s_valid = 0; s_data = '0;
        cfg_we = 0; cfg_idx = REG_NONE; cfg_data = '0;
        send_idle = 32; recv_idle = 76;
        repeat (4) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // directed: default settings, unknown index, initial variance before seeding
        write_cfg(REG_NONE, 64'hffff_ffff_ffff_ffff);
        write_cfg(REG_INIT_VAR, 64'd100000);
        send_item(32'h0002_8000, 32'h0000_4000);
        send_item(32'h0002_8000, 32'h0000_0000);
        send_item(32'h7fff_ffff, 32'h8000_0000);
        send_item(32'h8000_0000, 32'h7fff_ffff);
        send_item(32'h0005_0000, 32'h0002_8000);
        send_item(32'h0002_8000, 32'h0005_0000);
        send_item(32'hffff_ffff, 32'h0000_0001);
        // initial variance after seeding leaves the filter alone
        drain();
        write_cfg(REG_INIT_VAR, 64'd12345);
        send_item(32'h0000_0000, 32'h0000_0000);
        // zero process and measurement variance
        drain();
        write_cfg(REG_PROC_VAR, 64'd0);
        write_cfg(REG_MEAS_VAR, 64'd0);
        send_item(32'h0001_0000, 32'h0001_0000);
        drain();
        write_cfg(REG_MEAS_VAR, 64'h0000_0000_ffff_ffff);
        write_cfg(REG_PROC_VAR, 64'h0000_0000_ffff_ffff);
        send_item(32'h7fff_ffff, 32'h7fff_ffff);
        send_item(32'h8000_0000, 32'h8000_0000);
        drain();
        write_cfg(REG_SNAP_RAD, 64'h0000_0000_ffff_ffff);
        write_cfg(REG_LMARK_A, 64'h7fff_ffff_8000_0000);
        write_cfg(REG_LMARK_B, 64'h8000_0000_7fff_ffff);
        write_cfg(REG_LMARK_C, 64'h0000_0000_0000_0000);
        send_item(32'h0000_0000, 32'h0000_0000);
        send_item(32'h7fff_ffff, 32'h8000_0000);
        drain();
        write_cfg(REG_SNAP_RAD, 64'd0);
        send_item(32'h0000_0000, 32'h0000_0000);
        drain();

        // random phases with different settings and idle patterns
        for (int ph = 0; ph < 10; ph++) begin
            if (ph == 4) begin send_idle = 76; recv_idle = 32; end
            if (ph == 7) begin send_idle = 0; recv_idle = 0; end
            write_cfg(REG_PROC_VAR,
                      64'(ph == 1 ? 32'hffff_ffff : 32'($urandom_range(200000))));
            write_cfg(REG_MEAS_VAR, 64'(ph == 2 ? 32'd0 : 32'($urandom_range(200000))));
            write_cfg(REG_SNAP_RAD,
                      64'(ph == 3 ? 32'hffff_ffff : 32'($urandom_range(2000000))));
            write_cfg(REG_INIT_VAR, 64'($urandom));
            for (int l = 0; l < 3; l++)
                write_cfg(3'(int'(REG_LMARK_A) + l),
                          ph == 5 ? {$urandom, $urandom}
                                  : {near_coord(), near_coord()});
            for (int n = 0; n < 200; n++) begin
                send_random();
                if (n == 100) drain();
            end
            drain();
        end

        if (board.pending_q.size() == 0 && board.errors == 0)
            $display("position_kalman_landmark_snap test passed");
        else
            $display("position_kalman_landmark_snap test failed");
        $finish;
    end
endmodule

>>> position_kalman_landmark_snap.f
+incdir+src
src/pkls_pkg.sv
src/pkls_div.sv
src/position_kalman_landmark_snap.sv
tb/tb.sv
